FILE: rtl/chgs_pkg.sv
// shared command and status types for the convex hull core
package chgs_pkg;

    // read port selection for a memory read command
    typedef enum logic [1:0] {
        SRC_PMEM,
        SRC_SMEM,
        SRC_STK
    } t_src;

    // operand register that takes the read data
    typedef enum logic [1:0] {
        DST_NONE,
        DST_BASE,
        DST_A,
        DST_B
    } t_dst;

    // multiplier operation
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_CROSS,
        MUL_SQA,
        MUL_SQB
    } t_mul;

    typedef struct packed {
        logic load;
        logic rd_en;
        t_src rd_src;
        t_dst rd_dst;
        logic emit;
        logic last;
        t_mul mul;
        logic base_piv;
        logic swr;
        logic swr_piv;
        logic kwr;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic cross_pos;
        logic cross_zero;
        logic d_less;
        logic d_eq;
    } t_sts;

    // smallest set that goes through the scan
    localparam int unsigned SCAN_MIN = 3;

endpackage

FILE: rtl/convex_hull_graham_scan_core.sv
// top level of the graham scan convex hull core
//
// points load one beat per cycle while busy is low (start high); the beat with
// i_final_point set closes the set and raises busy. points past MAX_POINTS are
// dropped and every vertex of that set then carries o_overflow. the core then
// ranks each point about the pivot (lowest y, then lowest x) with one shared
// two-multiplier cross product unit, one point pair compared at a time. the
// stack scan follows: pops and pushes go one at a time, and a point is pushed
// without a turn test while the stack holds fewer than two vertices. finally the
// hull is emitted counter-clockwise from the pivot at one vertex per cycle, the
// last one marked by o_hull_last. sets of fewer than three points are echoed in
// input order. each result beat is on the outputs for exactly one cycle with
// o_hull_valid high; there is no backpressure, the receiver must take every
// beat. busy drops in the cycle after the last beat, and the next set may
// start loading then.
module convex_hull_graham_scan_core
    import chgs_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_final_point,
    output logic signed [COORD_BITS-1:0] o_hull_x,
    output logic signed [COORD_BITS-1:0] o_hull_y,
    output logic                         o_hull_last,
    output logic                         o_overflow,
    output logic                         o_hull_valid
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // controller to datapath commands and datapath status
    t_cmd          cmd;
    t_sts          sts;
    logic [IW-1:0] addr;
    logic [CW-1:0] count;
    logic [IW-1:0] piv_idx;

    chgs_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_final   (i_final_point),
        .o_busy    (busy),
        .i_count   (count),
        .i_piv_idx (piv_idx),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_addr    (addr)
    );

    chgs_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_addr       (addr),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .o_count      (count),
        .o_piv_idx    (piv_idx),
        .o_sts        (sts),
        .o_hull_x     (o_hull_x),
        .o_hull_y     (o_hull_y),
        .o_hull_last  (o_hull_last),
        .o_overflow   (o_overflow),
        .o_hull_valid (o_hull_valid)
    );

endmodule

FILE: rtl/chgs_dp.sv
// datapath: point, sorted and stack memories, operand registers, cross product unit
module chgs_dp
    import chgs_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cmd                              i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_addr,
    input  logic signed [COORD_BITS-1:0]      i_point_x,
    input  logic signed [COORD_BITS-1:0]      i_point_y,
    output logic [$clog2(MAX_POINTS+1)-1:0]   o_count,
    output logic [$clog2(MAX_POINTS)-1:0]     o_piv_idx,
    output t_sts                              o_sts,
    output logic signed [COORD_BITS-1:0]      o_hull_x,
    output logic signed [COORD_BITS-1:0]      o_hull_y,
    output logic                              o_hull_last,
    output logic                              o_overflow,
    output logic                              o_hull_valid
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int RW = PW + 1;

    logic [2*CB-1:0] r_pmem [MAX_POINTS];
    logic [2*CB-1:0] r_smem [MAX_POINTS];
    logic [2*CB-1:0] r_stk  [MAX_POINTS];
    logic [2*CB-1:0] r_prd, r_srd, r_krd, rdata;

    logic [CW-1:0]   r_count;
    logic            r_dropped;
    logic signed [CB-1:0] r_px, r_py;
    logic [IW-1:0]   r_pidx;
    t_src            r_ld_src;
    t_dst            r_ld_dst;
    logic            r_em_pend, r_em_last, r_em_ovf;
    logic signed [CB-1:0] r_bx, r_by, r_ax, r_ay, r_cx, r_cy;
    t_mul            r_mode;
    logic signed [PW-1:0] r_pa, r_pb;
    logic signed [RW-1:0] r_cross, r_da, r_db;

    logic            store_ok;
    logic            new_piv;
    logic signed [DW-1:0] dxa, dya, dxb, dyb;
    logic signed [DW-1:0] m1a, m1b, m2a, m2b;

    assign store_ok = i_cmd.load && (r_count < CW'(MAX_POINTS));
    assign new_piv  = (r_count == '0) || (i_point_y < r_py) ||
                      ((i_point_y == r_py) && (i_point_x < r_px));

    // memories
    always_ff @(posedge i_clk) begin
        if (store_ok) begin
            r_pmem[r_count[IW-1:0]] <= {i_point_x, i_point_y};
        end
        if (i_cmd.rd_en && i_cmd.rd_src == SRC_PMEM) begin
            r_prd <= r_pmem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.swr_piv) begin
            r_smem[IW'(0)] <= {r_px, r_py};
        end else if (i_cmd.swr) begin
            r_smem[i_addr] <= {r_cx, r_cy};
        end
        if (i_cmd.rd_en && i_cmd.rd_src == SRC_SMEM) begin
            r_srd <= r_smem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.kwr) begin
            r_stk[i_addr] <= {r_cx, r_cy};
        end
        if (i_cmd.rd_en && i_cmd.rd_src == SRC_STK) begin
            r_krd <= r_stk[i_addr];
        end
    end

    always_comb begin
        case (r_ld_src)
            SRC_PMEM: rdata = r_prd;
            SRC_SMEM: rdata = r_srd;
            SRC_STK:  rdata = r_krd;
            default:  rdata = r_prd;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_dropped    <= 1'b0;
            r_ld_src     <= SRC_PMEM;
            r_ld_dst     <= DST_NONE;
            r_em_pend    <= 1'b0;
            r_em_last    <= 1'b0;
            r_em_ovf     <= 1'b0;
            r_mode       <= MUL_NONE;
            o_hull_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else if (store_ok) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.load) begin
                r_dropped <= 1'b1;
            end
            r_ld_src     <= i_cmd.rd_src;
            r_ld_dst     <= i_cmd.rd_en ? i_cmd.rd_dst : DST_NONE;
            r_em_pend    <= i_cmd.rd_en && i_cmd.emit;
            r_em_last    <= i_cmd.last;
            r_em_ovf     <= r_dropped;
            r_mode       <= i_cmd.mul;
            o_hull_valid <= r_em_pend;
        end
    end

    // pivot tracking and operand registers
    always_ff @(posedge i_clk) begin
        if (store_ok && new_piv) begin
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_pidx <= r_count[IW-1:0];
        end
        if (i_cmd.base_piv) begin
            r_bx <= r_px;
            r_by <= r_py;
        end
        case (r_ld_dst)
            DST_BASE: begin
                r_bx <= $signed(rdata[2*CB-1:CB]);
                r_by <= $signed(rdata[CB-1:0]);
            end
            DST_A: begin
                r_ax <= $signed(rdata[2*CB-1:CB]);
                r_ay <= $signed(rdata[CB-1:0]);
            end
            DST_B: begin
                r_cx <= $signed(rdata[2*CB-1:CB]);
                r_cy <= $signed(rdata[CB-1:0]);
            end
            default: ;
        endcase
        if (r_em_pend) begin
            o_hull_x    <= $signed(rdata[2*CB-1:CB]);
            o_hull_y    <= $signed(rdata[CB-1:0]);
            o_hull_last <= r_em_last;
            o_overflow  <= r_em_ovf;
        end
    end

    // offsets from the base point
    assign dxa = DW'(r_ax) - DW'(r_bx);
    assign dya = DW'(r_ay) - DW'(r_by);
    assign dxb = DW'(r_cx) - DW'(r_bx);
    assign dyb = DW'(r_cy) - DW'(r_by);

    always_comb begin
        case (i_cmd.mul)
            MUL_CROSS: begin
                m1a = dxa; m1b = dyb; m2a = dxb; m2b = dya;
            end
            MUL_SQA: begin
                m1a = dxa; m1b = dxa; m2a = dya; m2b = dya;
            end
            MUL_SQB: begin
                m1a = dxb; m1b = dxb; m2a = dyb; m2b = dyb;
            end
            default: begin
                m1a = '0; m1b = '0; m2a = '0; m2b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pa <= PW'(m1a) * PW'(m1b);
        r_pb <= PW'(m2a) * PW'(m2b);
        case (r_mode)
            MUL_CROSS: r_cross <= RW'(r_pa) - RW'(r_pb);
            MUL_SQA:   r_da    <= RW'(r_pa) + RW'(r_pb);
            MUL_SQB:   r_db    <= RW'(r_pa) + RW'(r_pb);
            default: ;
        endcase
    end

    assign o_sts.cross_pos  = (r_cross > 0);
    assign o_sts.cross_zero = (r_cross == '0);
    assign o_sts.d_less     = (r_da < r_db);
    assign o_sts.d_eq       = (r_da == r_db);
    assign o_count          = r_count;
    assign o_piv_idx        = r_pidx;

endmodule

FILE: rtl/chgs_ctrl.sv
// controller: load, angular rank sort, stack scan, hull emission and small-set echo sequencing
module chgs_ctrl
    import chgs_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_final,
    output logic                              o_busy,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   i_count,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_piv_idx,
    input  t_sts                              i_sts,
    output t_cmd                              o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]     o_addr
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // step numbers inside the compare sequences
    localparam logic [2:0] SW_CROSS = 3'd1;
    localparam logic [2:0] SW_SQA   = 3'd2;
    localparam logic [2:0] SW_SQB   = 3'd3;
    localparam logic [2:0] SW_CMP   = 3'd5;
    localparam logic [2:0] BW_READY = 3'd1;
    localparam logic [2:0] KW_CROSS = 3'd2;
    localparam logic [2:0] KW_CHECK = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_SORT_I,
        S_SORT_J,
        S_SORT_RUN,
        S_SCAN_LD,
        S_SCAN_WB,
        S_SCAN_TEST,
        S_SCAN_RUN,
        S_EMIT,
        S_ECHO,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_depth, n_depth;
    logic [IW-1:0] r_rank, n_rank;
    logic [2:0]    r_w, n_w;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_depth = r_depth;
        n_rank  = r_rank;
        n_w     = r_w;
        o_cmd   = '0;
        o_addr  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_final) n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_k = '0;
                n_i = '0;
                if (i_count < CW'(SCAN_MIN)) begin
                    n_state = S_ECHO;
                end else begin
                    o_cmd.swr_piv  = 1'b1;
                    o_cmd.base_piv = 1'b1;
                    n_state        = S_SORT_I;
                end
            end
            S_SORT_I: begin
                if (r_i == i_count) begin
                    n_i     = '0;
                    n_depth = '0;
                    n_state = S_SCAN_LD;
                end else if (r_i[IW-1:0] == i_piv_idx) begin
                    n_i = r_i + CW'(1);
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = SRC_PMEM;
                    o_cmd.rd_dst = DST_B;
                    o_addr       = r_i[IW-1:0];
                    n_rank       = IW'(1);
                    n_j          = '0;
                    n_state      = S_SORT_J;
                end
            end
            S_SORT_J: begin
                if (r_j == i_count) begin
                    o_cmd.swr = 1'b1;
                    o_addr    = r_rank;
                    n_i       = r_i + CW'(1);
                    n_state   = S_SORT_I;
                end else if (r_j == r_i || r_j[IW-1:0] == i_piv_idx) begin
                    n_j = r_j + CW'(1);
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = SRC_PMEM;
                    o_cmd.rd_dst = DST_A;
                    o_addr       = r_j[IW-1:0];
                    n_w          = '0;
                    n_state      = S_SORT_RUN;
                end
            end
            S_SORT_RUN: begin
                n_w = r_w + 3'd1;
                if (r_w == SW_CROSS) o_cmd.mul = MUL_CROSS;
                if (r_w == SW_SQA)   o_cmd.mul = MUL_SQA;
                if (r_w == SW_SQB)   o_cmd.mul = MUL_SQB;
                if (r_w == SW_CMP) begin
                    // point j ranks ahead of point i, equal keys by input order
                    if (i_sts.cross_pos ||
                        (i_sts.cross_zero && i_sts.d_less) ||
                        (i_sts.cross_zero && i_sts.d_eq && (r_j < r_i))) begin
                        n_rank = r_rank + IW'(1);
                    end
                    n_j     = r_j + CW'(1);
                    n_state = S_SORT_J;
                end
            end
            S_SCAN_LD: begin
                if (r_i == i_count) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = SRC_SMEM;
                    o_cmd.rd_dst = DST_B;
                    o_addr       = r_i[IW-1:0];
                    n_w          = '0;
                    n_state      = S_SCAN_WB;
                end
            end
            S_SCAN_WB: begin
                n_w = r_w + 3'd1;
                if (r_w == BW_READY) n_state = S_SCAN_TEST;
            end
            S_SCAN_TEST: begin
                if (r_depth > CW'(1)) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = SRC_STK;
                    o_cmd.rd_dst = DST_BASE;
                    o_addr       = IW'(r_depth - CW'(2));
                    n_w          = '0;
                    n_state      = S_SCAN_RUN;
                end else begin
                    o_cmd.kwr = 1'b1;
                    o_addr    = r_depth[IW-1:0];
                    n_depth   = r_depth + CW'(1);
                    n_i       = r_i + CW'(1);
                    n_state   = S_SCAN_LD;
                end
            end
            S_SCAN_RUN: begin
                n_w = r_w + 3'd1;
                if (r_w == 3'd0) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = SRC_STK;
                    o_cmd.rd_dst = DST_A;
                    o_addr       = IW'(r_depth - CW'(1));
                end
                if (r_w == KW_CROSS) o_cmd.mul = MUL_CROSS;
                if (r_w == KW_CHECK) begin
                    if (!i_sts.cross_pos) begin
                        // right turn or collinear: pop
                        n_depth = r_depth - CW'(1);
                        n_state = S_SCAN_TEST;
                    end else begin
                        o_cmd.kwr = 1'b1;
                        o_addr    = r_depth[IW-1:0];
                        n_depth   = r_depth + CW'(1);
                        n_i       = r_i + CW'(1);
                        n_state   = S_SCAN_LD;
                    end
                end
            end
            S_EMIT: begin
                if (r_k == r_depth) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = SRC_STK;
                    o_cmd.rd_dst = DST_NONE;
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = (r_k + CW'(1) == r_depth);
                    o_addr       = r_k[IW-1:0];
                    n_k          = r_k + CW'(1);
                end
            end
            S_ECHO: begin
                if (r_k == i_count) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = SRC_PMEM;
                    o_cmd.rd_dst = DST_NONE;
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = (r_k + CW'(1) == i_count);
                    o_addr       = r_k[IW-1:0];
                    n_k          = r_k + CW'(1);
                end
            end
            S_DONE: begin
                o_cmd.clear = 1'b1;
                n_depth     = '0;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_depth <= '0;
            r_rank  <= '0;
            r_w     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_depth <= n_depth;
            r_rank  <= n_rank;
            r_w     <= n_w;
        end
    end

endmodule
